// File: rtl/spfa_shortest_paths_macros.svh
// Assertion macros for the shortest-path block.
// Used by the top level only.
`ifndef SPFA_SHORTEST_PATHS_MACROS_SVH
`define SPFA_SHORTEST_PATHS_MACROS_SVH
`define SPFA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("spfa check failed");
`define SPFA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("spfa check failed");
`endif

// File: rtl/spfa_pkg.sv
// Shared types and constants for the shortest-path block.
// No dependencies.
package spfa_pkg;
  localparam int MaxVertices = 32;
  localparam int MaxEdges    = 256;
  localparam int VBits       = 5;
  localparam int EBits       = 8;
  localparam int LBits       = 9;
  localparam int WBits       = 16;
  localparam int RBits       = 14;
  localparam logic [LBits-1:0] LinkNull = LBits'(MaxEdges);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0, CMD_RUN = 2'd1, CMD_CLR = 2'd2, CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;

  typedef struct packed {
    logic add;
    logic clr;
    logic init;
    logic pop;
    logic edge_rd;
    logic relax;
    logic emit_rd;
  } spfa_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic link_null;
    logic v_ok;
    logic better;
    logic over_bound;
  } spfa_sts_t;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                logic signed [WBits-1:0] w);
    logic signed [32:0] s;
    s = {a[31], a} + 33'(signed'(w));
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction
endpackage

// File: rtl/spfa_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
interface spfa_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/spfa_ram.sv
// Generic single-port write, single read RAM with registered read.
// No dependencies.
module spfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/spfa_datapath.sv
// Datapath: edge store, vertex stores, work queue, relax counter.
// Depends on spfa_pkg and spfa_ram.
module spfa_datapath import spfa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spfa_cmd_t               cmd,
  input  logic [VBits-1:0]        add_from,
  input  logic [VBits-1:0]        add_to,
  input  logic signed [WBits-1:0] add_w,
  input  logic [VBits:0]          n_vert,
  input  logic [VBits-1:0]        src,
  input  logic [VBits-1:0]        emit_v,
  output spfa_sts_t               sts,
  output logic signed [31:0]      o_dist,
  output logic                    o_reach,
  output logic [VBits-1:0]        o_pred,
  output logic                    o_full
);
  logic [LBits-1:0] head_r [MaxVertices];
  logic [LBits-1:0] ecount_r;
  logic             full_r;
  logic signed [31:0] dist_r [MaxVertices];
  logic [MaxVertices-1:0] reach_r, queued_r;
  logic [VBits-1:0] pred_r [MaxVertices];
  logic [VBits-1:0] queue_r [MaxVertices];
  logic [VBits-1:0] qrd_r;
  logic [VBits:0]   qlen_r;
  logic [RBits-1:0] rcnt_r;
  logic [RBits-1:0] bound_r;
  logic [VBits-1:0] u_r;
  logic [LBits-1:0] e_r;
  logic             add_ok;
  logic             src_ok;
  logic [VBits-1:0] e_to;
  logic signed [WBits-1:0] e_w;
  logic [LBits-1:0] e_next;
  logic signed [31:0] nd;

  assign add_ok = (ecount_r < LBits'(MaxEdges));

  spfa_ram #(.Width(VBits+WBits+LBits), .Depth(MaxEdges)) u_edges (
    .clk(clk), .we(cmd.add && add_ok), .waddr(ecount_r[EBits-1:0]),
    .wdata({add_to, add_w, head_r[add_from]}),
    .raddr(e_r[EBits-1:0]), .rdata({e_to, e_w, e_next})
  );

  assign nd = sat_add(dist_r[u_r], e_w);
  assign src_ok = ({1'b0, src} < n_vert);
  assign sts.q_empty    = (qlen_r == '0);
  assign sts.link_null  = e_r[EBits];
  assign sts.v_ok       = ({1'b0, e_to} < n_vert);
  assign sts.better     = !reach_r[e_to] || (nd < dist_r[e_to]);
  assign sts.over_bound = (rcnt_r >= bound_r);
  assign o_full = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxVertices; i++) head_r[i] <= LinkNull;
      ecount_r <= '0;
      full_r <= 1'b0;
      reach_r <= '0;
      queued_r <= '0;
      qlen_r <= '0;
      qrd_r <= '0;
      rcnt_r <= '0;
    end else begin
      if (cmd.clr) begin
        for (int i = 0; i < MaxVertices; i++) head_r[i] <= LinkNull;
        ecount_r <= '0;
        full_r <= 1'b0;
      end
      if (cmd.add) begin
        if (add_ok) begin
          head_r[add_from] <= ecount_r;
          ecount_r <= ecount_r + 1'b1;
        end else begin
          full_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        qrd_r <= '0;
        rcnt_r <= '0;
        bound_r <= RBits'(n_vert) * RBits'(ecount_r);
        reach_r <= src_ok ? (MaxVertices'(1) << src) : '0;
        queued_r <= src_ok ? (MaxVertices'(1) << src) : '0;
        qlen_r <= src_ok ? (VBits+1)'(1) : '0;
        if (src_ok) begin
          pred_r[src] <= src;
          dist_r[src] <= '0;
          queue_r[0] <= src;
        end
      end
      if (cmd.pop) begin
        u_r <= queue_r[qrd_r];
        e_r <= head_r[queue_r[qrd_r]];
        queued_r[queue_r[qrd_r]] <= 1'b0;
        qrd_r <= qrd_r + 1'b1;
        qlen_r <= qlen_r - 1'b1;
      end
      if (cmd.edge_rd) begin
        e_r <= e_next;
      end
      if (cmd.relax) begin
        rcnt_r <= rcnt_r + 1'b1;
        dist_r[e_to] <= nd;
        reach_r[e_to] <= 1'b1;
        pred_r[e_to] <= u_r;
        if (!queued_r[e_to]) begin
          queue_r[qrd_r + VBits'(qlen_r)] <= e_to;
          queued_r[e_to] <= 1'b1;
          qlen_r <= qlen_r + 1'b1;
        end
      end
      if (cmd.emit_rd) begin
        o_reach <= reach_r[emit_v];
        o_dist <= reach_r[emit_v] ? dist_r[emit_v] : '0;
        o_pred <= reach_r[emit_v] ? pred_r[emit_v] : '0;
      end
    end
  end
endmodule

// File: rtl/spfa_ctrl.sv
// Controller state machine sequencing edge adds, search and result emit.
// Depends on spfa_pkg.
module spfa_ctrl import spfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  cmd_t             req_cmd,
  output logic             req_ready,
  input  spfa_sts_t        sts,
  input  logic [VBits:0]   n_vert,
  output spfa_cmd_t        cmd,
  output logic [VBits-1:0] emit_v,
  output logic             res_valid,
  output logic             res_last,
  output logic             res_neg,
  input  logic             res_ready
);
  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_POP, S_FETCH, S_EDGE, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [VBits-1:0] v_r, v_nxt;
  logic neg_r, neg_nxt;
  logic accept;

  assign req_ready = (state_r == S_IDLE);
  assign accept = req_valid && req_ready;
  assign emit_v = v_r;
  assign res_valid = (state_r == S_EMIT);
  assign res_neg = neg_r;
  assign res_last = ({1'b0, v_r} == n_vert - 1'b1);

  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    neg_nxt = neg_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_cmd)
            CMD_ADD: cmd.add = 1'b1;
            CMD_CLR: cmd.clr = 1'b1;
            CMD_RUN: state_nxt = S_INIT;
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        neg_nxt = 1'b0;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          v_nxt = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.pop = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.link_null) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (sts.v_ok && sts.better && sts.over_bound) begin
          neg_nxt = 1'b1;
          v_nxt = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.relax = sts.v_ok && sts.better;
          cmd.edge_rd = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          if (res_last) begin
            state_nxt = S_IDLE;
          end else begin
            v_nxt = v_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v_r <= '0;
      neg_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r <= v_nxt;
      neg_r <= neg_nxt;
    end
  end
endmodule

// File: rtl/spfa_shortest_paths.sv
// Top level of the SPFA shortest-path block: channels, APB registers, assertions.
// Depends on spfa_pkg, spfa_ctrl, spfa_datapath, macros header.
// Usage:
//   Input requests carry command, edge_from, edge_to, edge_weight. An add or
//   clear request is done in the idle state, so they can follow back to back.
//   A run request starts a search from source_vertex over vertices 0..n-1,
//   n being vertex_count limited to 1..32, then emits one result per vertex,
//   in order, with last on the final one.
//   Run steps: an init state, then a pop and a fetch state per queue pop, a
//   fetch and an edge state per scanned edge and a final empty-queue check;
//   then an emit-read and an emit state per result.
//   The block takes one request at a time; in_ready is low during a run.
//   Reset empties the edge store and sets vertex_count 32, source_vertex 0.
//   When the receiver stalls, the current result holds until taken.
//   Registers: vertex_count at 0x0, source_vertex at 0x4, for the user to write
//   only while idle (not enforced); writes to other addresses are ignored.
`include "spfa_shortest_paths_macros.svh"
module spfa_shortest_paths import spfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_edge_from,
  input  logic [4:0]  in_edge_to,
  input  logic signed [15:0] in_edge_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_vertex,
  output logic signed [31:0] out_distance,
  output logic        out_reachable,
  output logic [4:0]  out_predecessor,
  output logic        out_negative_cycle,
  output logic        out_edge_store_full,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [VBits:0]   vcount_r;
  logic [VBits-1:0] source_r;
  logic [VBits:0]   n_vert;
  spfa_cmd_t        cmd;
  spfa_sts_t        sts;
  logic [VBits-1:0] emit_v;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 6'd32;
      source_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SOURCE[0] && cfg_paddr[1:0] == 2'b00) begin
        source_r <= cfg_pwdata[4:0];
      end else if (cfg_paddr == {REG_VCOUNT[0], 2'b00}) begin
        vcount_r <= cfg_pwdata[5:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      {REG_VCOUNT[0], 2'b00}: cfg_prdata = {26'd0, vcount_r};
      {REG_SOURCE[0], 2'b00}: cfg_prdata = {27'd0, source_r};
      default: cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (vcount_r == '0) n_vert = 6'd1;
    else if (vcount_r > 6'(MaxVertices)) n_vert = 6'(MaxVertices);
    else n_vert = vcount_r;
  end

  spfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .req_valid(in_valid), .req_cmd(cmd_t'(in_command)),
    .req_ready(in_ready), .sts(sts), .n_vert(n_vert), .cmd(cmd), .emit_v(emit_v),
    .res_valid(out_valid), .res_last(out_last), .res_neg(out_negative_cycle),
    .res_ready(out_ready)
  );

  spfa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .add_from(in_edge_from),
    .add_to(in_edge_to), .add_w(in_edge_weight), .n_vert(n_vert),
    .src(source_r), .emit_v(emit_v), .sts(sts), .o_dist(out_distance),
    .o_reach(out_reachable), .o_pred(out_predecessor),
    .o_full(out_edge_store_full)
  );

  assign out_vertex = emit_v;

  `SPFA_ASSERT_IMPL(a_busy_no_ready, out_valid, !in_ready)
  `SPFA_ASSERT_IMPL(a_unreach_zero, out_valid && !out_reachable, out_distance == '0)
  `SPFA_ASSERT_NEXT(a_last_idle, out_valid && out_ready && out_last, in_ready)
endmodule

// File: test/spfa_shortest_paths_tb.sv
// Self-checking testbench for spfa_shortest_paths: edge adds, clears and runs
// checked against an in-bench shortest-path predictor, with APB config writes.
// Depends on spfa_pkg, spfa_if and the spfa_shortest_paths RTL.
module spfa_shortest_paths_tb;
  import spfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t              command;
    logic [4:0]        edge_from;
    logic [4:0]        edge_to;
    logic signed [15:0] edge_weight;
  } edge_req_t;

  typedef struct packed {
    logic [4:0]         vertex;
    logic signed [31:0] distance;
    logic               reachable;
    logic [4:0]         predecessor;
    logic               negative_cycle;
    logic               edge_store_full;
    logic               last;
  } vertex_res_t;

  typedef enum {ROW_CFG, ROW_ITEM, ROW_HOLD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    edge_req_t   req;
    bit          typed;
    vertex_res_t typed_res;
  } stim_row_t;

  localparam longint CycleLimit = 3000000;
  localparam int HoldCycles = 500;

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic in_ready_w, out_valid_w;
  logic [4:0] o_vertex, o_pred;
  logic signed [31:0] o_dist;
  logic o_reach, o_neg, o_full, o_last;

  spfa_if #(.payload_t(edge_req_t))   in_ch ();
  spfa_if #(.payload_t(vertex_res_t)) out_ch ();

  assign in_ch.ready  = in_ready_w;
  assign out_ch.valid = out_valid_w;
  assign out_ch.data  = {o_vertex, o_dist, o_reach, o_pred, o_neg, o_full, o_last};

  spfa_shortest_paths uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ready_w),
    .in_command(in_ch.data.command), .in_edge_from(in_ch.data.edge_from),
    .in_edge_to(in_ch.data.edge_to), .in_edge_weight(in_ch.data.edge_weight),
    .out_valid(out_valid_w), .out_ready(out_ch.ready),
    .out_vertex(o_vertex), .out_distance(o_dist), .out_reachable(o_reach),
    .out_predecessor(o_pred), .out_negative_cycle(o_neg),
    .out_edge_store_full(o_full), .out_last(o_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [4:0]         adj_head_v[MaxEdges];
  logic signed [15:0] adj_weight[MaxEdges];
  int unsigned        adj_next[MaxEdges];
  int unsigned        list_head[MaxVertices];
  int unsigned        stored_edges;
  bit                 store_overflow;
  int unsigned        vcount_reg, source_reg;

  vertex_res_t expected_vertices[$];
  int  errors, runs_done, neg_runs, results_seen, items_sent;
  int  src_idle_pct, snk_idle_pct;
  int  hold_req, hold_seen, hold_left;
  longint cycles = 0;
  stim_row_t rows[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_vertices.size());
      $display("spfa_shortest_paths_tb: FAIL");
      $finish;
    end
  end

  function automatic void clear_store();
    for (int i = 0; i < MaxVertices; i++) list_head[i] = MaxEdges;
    stored_edges = 0;
    store_overflow = 0;
  endfunction

  function automatic void search_paths(ref vertex_res_t res[$]);
    int unsigned n, src, bound, relax, u, v, e;
    longint dist_v[MaxVertices];
    longint nd;
    bit reached[MaxVertices];
    bit queued[MaxVertices];
    logic [4:0] pred[MaxVertices];
    int unsigned work[$];
    bit neg;
    vertex_res_t r;
    n = (vcount_reg == 0) ? 1 : (vcount_reg > MaxVertices ? MaxVertices : vcount_reg);
    src = source_reg;
    bound = n * stored_edges;
    relax = 0;
    neg = 0;
    for (int i = 0; i < MaxVertices; i++) begin
      dist_v[i] = 0; reached[i] = 0; queued[i] = 0; pred[i] = '0;
    end
    if (src < n) begin
      reached[src] = 1;
      pred[src] = src[4:0];
      work = {work, src};
      queued[src] = 1;
    end
    while (work.size() > 0 && !neg) begin
      u = work.pop_front();
      queued[u] = 0;
      e = list_head[u];
      while (e < MaxEdges && !neg) begin
        v = adj_head_v[e];
        if (v < n) begin
          nd = dist_v[u] + longint'(adj_weight[e]);
          if (nd > 64'sd2147483647) nd = 64'sd2147483647;
          if (nd < -64'sd2147483648) nd = -64'sd2147483648;
          if (!reached[v] || nd < dist_v[v]) begin
            if (relax >= bound) neg = 1;
            else begin
              relax++;
              dist_v[v] = nd;
              reached[v] = 1;
              pred[v] = u[4:0];
              if (!queued[v]) begin
                work = {work, v};
                queued[v] = 1;
              end
            end
          end
        end
        e = adj_next[e];
      end
    end
    for (int i = 0; i < n; i++) begin
      r.vertex = i[4:0];
      r.distance = reached[i] ? dist_v[i][31:0] : '0;
      r.reachable = reached[i];
      r.predecessor = reached[i] ? pred[i] : '0;
      r.negative_cycle = neg;
      r.edge_store_full = store_overflow;
      r.last = (i + 1 == n);
      res = {res, r};
    end
    runs_done++;
    if (neg) neg_runs++;
  endfunction

  function automatic void apply_request(edge_req_t q, ref vertex_res_t res[$]);
    case (q.command)
      CMD_ADD: begin
        if (stored_edges >= MaxEdges) store_overflow = 1;
        else begin
          adj_head_v[stored_edges] = q.edge_to;
          adj_weight[stored_edges] = q.edge_weight;
          adj_next[stored_edges] = list_head[q.edge_from];
          list_head[q.edge_from] = stored_edges;
          stored_edges++;
        end
      end
      CMD_CLR: clear_store();
      CMD_RUN: search_paths(res);
      default: ;
    endcase
  endfunction

  // result side: random stalls, long hold on request, compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.data);
          errors++;
        end else if (out_ch.data !== expected_vertices[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time,
                   expected_vertices[0], out_ch.data);
          errors++;
          void'(expected_vertices.pop_front());
        end else void'(expected_vertices.pop_front());
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        out_ch.ready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 0;
      end else
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_request(edge_req_t q, bit typed = 0, vertex_res_t typed_res = '0);
    vertex_res_t res[$];
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= q;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(q, res);
    if (typed) expected_vertices = {expected_vertices, typed_res};
    else foreach (res[i]) expected_vertices = {expected_vertices, res[i]};
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] exp_val;
    exp_val = (idx == REG_VCOUNT) ? {26'd0, val[5:0]} : {27'd0, val[4:0]};
    drain_results();
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    if (!cfg_pready || cfg_prdata !== exp_val) begin
      $display("%0t: register readback expected %h actual %h", $time, exp_val,
               cfg_prdata);
      errors++;
    end
    cfg_psel <= 0;
    cfg_penable <= 0;
    if (idx == REG_VCOUNT) vcount_reg = val[5:0];
    else if (idx == REG_SOURCE) source_reg = val[4:0];
  endtask

  function automatic edge_req_t mk_req(cmd_t c, int f, int t, int w);
    edge_req_t q;
    q.command = c;
    q.edge_from = f[4:0];
    q.edge_to = t[4:0];
    q.edge_weight = w[15:0];
    return q;
  endfunction

  function automatic void row_cfg(logic [1:0] idx, logic [31:0] val);
    stim_row_t r;
    r.kind = ROW_CFG; r.reg_idx = idx; r.reg_val = val; r.typed = 0;
    rows = {rows, r};
  endfunction

  function automatic void row_req(row_kind_t k, edge_req_t q, bit typed = 0,
                                  vertex_res_t tr = '0);
    stim_row_t r;
    r.kind = k; r.req = q; r.typed = typed; r.typed_res = tr;
    rows = {rows, r};
  endfunction

  task automatic random_sequence(bit reconfigure);
    int n, nv, k;
    edge_req_t q;
    if (reconfigure) begin
      case ($urandom_range(9))
        0: n = 32;
        1: n = $urandom_range(1) ? 0 : 63;
        2: n = $urandom_range(9, 31);
        default: n = $urandom_range(1, 8);
      endcase
      write_reg(REG_VCOUNT, (n & 32'h3f) | ({$urandom} & ~32'h3f));
      nv = (vcount_reg == 0) ? 1 : (vcount_reg > 32 ? 32 : vcount_reg);
      write_reg(REG_SOURCE, ($urandom_range(7) == 0) ? $urandom : $urandom_range(nv - 1));
    end
    nv = (vcount_reg == 0) ? 1 : (vcount_reg > 32 ? 32 : vcount_reg);
    if ($urandom_range(3) != 0 || stored_edges > 40) begin
      q = mk_req(CMD_CLR, $urandom, $urandom, $urandom);
      send_request(q);
    end
    k = $urandom_range(1, 10);
    repeat (k) begin
      q = mk_req(CMD_ADD, $urandom_range(nv - 1), $urandom_range(nv - 1),
                 $urandom_range(120) - 20);
      if ($urandom_range(5) == 0) q.edge_weight = 16'($urandom);
      if ($urandom_range(7) == 0) q.edge_to = 5'($urandom);
      if ($urandom_range(9) == 0) q.edge_from = 5'($urandom);
      send_request(q);
      if ($urandom_range(15) == 0) begin
        q = mk_req(CMD_NOP, $urandom, $urandom, $urandom);
        send_request(q);
      end
    end
    q = mk_req(CMD_RUN, $urandom, $urandom, $urandom);
    send_request(q);
  endtask

  initial begin
    rst_n = 0;
    errors = 0; runs_done = 0; neg_runs = 0; results_seen = 0; items_sent = 0;
    hold_req = 0;
    src_idle_pct = 38;
    snk_idle_pct = 59;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    clear_store();
    vcount_reg = 32;
    source_reg = 0;

    row_cfg(REG_VCOUNT, 32'd0);
    row_req(ROW_ITEM, mk_req(CMD_RUN, 31, 31, -1), 1, '{5'd0, 32'sd0, 1'b1, 5'd0, 1'b0, 1'b0, 1'b1});
    row_cfg(REG_SOURCE, 32'hffff_ffff);
    row_req(ROW_ITEM, mk_req(CMD_RUN, 0, 0, 0), 1, '{5'd0, 32'sd0, 1'b0, 5'd0, 1'b0, 1'b0, 1'b1});
    row_cfg(REG_SOURCE, 32'd0);
    row_req(ROW_ITEM, mk_req(CMD_RUN, 0, 0, 0));
    row_req(ROW_ITEM, mk_req(CMD_CLR, 31, 0, 32767));
    row_req(ROW_ITEM, mk_req(CMD_NOP, 31, 31, -32768));
    row_cfg(REG_VCOUNT, 32'd63);
    row_req(ROW_ITEM, mk_req(CMD_ADD, 0, 1, 32767));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 1, 31, -32768));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 31, 0, 5));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 0, 2, 3));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 2, 1, -1));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 0, 3, 2));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 3, 1, 0));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 5, 20, 1));
    row_req(ROW_HOLD, mk_req(CMD_RUN, 0, 0, 0));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 3, 4, 7));
    row_req(ROW_ITEM, mk_req(CMD_RUN, 0, 0, 0));
    row_cfg(REG_VCOUNT, 32'd4);
    row_cfg(REG_SOURCE, 32'd2);
    row_req(ROW_ITEM, mk_req(CMD_RUN, 0, 0, 0));
    row_req(ROW_ITEM, mk_req(CMD_CLR, 0, 0, 0));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 0, 1, -1));
    row_req(ROW_ITEM, mk_req(CMD_ADD, 1, 0, -1));
    row_cfg(REG_VCOUNT, 32'd2);
    row_cfg(REG_SOURCE, 32'd0);
    row_req(ROW_ITEM, mk_req(CMD_RUN, 0, 0, 0));
    row_cfg(REG_VCOUNT, 32'd32);

    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG:  write_reg(rows[i].reg_idx, rows[i].reg_val);
        ROW_ITEM: send_request(rows[i].req, rows[i].typed, rows[i].typed_res);
        ROW_HOLD: begin
          hold_req++;
          send_request(rows[i].req);
        end
        default: ;
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 59 : 0;
      snk_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 38 : 0;
      drain_results();
      hold_req++;
      random_sequence(0);
      while (items_sent < 21 + 40 * (phase + 1))
        random_sequence($urandom_range(1));
    end

    drain_results();
    $display("covered %0d requests, %0d runs (%0d with a negative cycle), %0d vertex results",
             items_sent, runs_done, neg_runs, results_seen);
    $display("config extremes, unreachable source, long receiver stalls, three idle mixes");
    if (errors == 0)
      $display("spfa_shortest_paths_tb: PASS");
    else
      $display("spfa_shortest_paths_tb: FAIL");
    $finish;
  end
endmodule

// File: spfa_shortest_paths.f
+incdir+rtl
rtl/spfa_pkg.sv
rtl/spfa_if.sv
rtl/spfa_ram.sv
rtl/spfa_datapath.sv
rtl/spfa_ctrl.sv
rtl/spfa_shortest_paths.sv
test/spfa_shortest_paths_tb.sv
